### rtl/hrs_pkg.sv
`timescale 1ns / 1ps

package hrs_pkg;

    localparam int OUTPUT_WIDTH = 320;
    localparam int PIX_W        = 16;
    localparam int WIDTH_W      = 9;
    localparam int OL_W         = $clog2(OUTPUT_WIDTH + 1);
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int DIV_CNT_W    = $clog2(WIDTH_W);

    localparam logic [WIDTH_W-1:0] OUT_W_W  = WIDTH_W'(OUTPUT_WIDTH);
    localparam logic [WIDTH_W-1:0] MIN_STEP = WIDTH_W'(2);

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [WIDTH_W-1:0] width_t;

    typedef struct packed {
        logic   busy;
        logic   done;
        width_t step;
    } div_status_t;

    function automatic pixel_t avg565(input pixel_t a, input pixel_t b);
        logic [5:0] r;
        logic [6:0] g;
        logic [5:0] bl;
        r  = {1'b0, a[15:11]} + {1'b0, b[15:11]};
        g  = {1'b0, a[10:5]} + {1'b0, b[10:5]};
        bl = {1'b0, a[4:0]} + {1'b0, b[4:0]};
        return {r[5:1], g[6:1], bl[5:1]};
    endfunction

endpackage

### rtl/hrs_step_div.sv
`timescale 1ns / 1ps

module hrs_step_div import hrs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  width_t      divisor,
    output div_status_t status
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    width_t               rem_reg, rem_next;
    width_t               quo_reg, quo_next;
    width_t               dsr_reg, dsr_next;
    logic [WIDTH_W:0]     shifted;
    logic                 fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[WIDTH_W-1]};
        fits      = shifted >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = OUT_W_W;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? WIDTH_W'(shifted - {1'b0, dsr_reg}) : shifted[WIDTH_W-1:0];
            quo_next = {quo_reg[WIDTH_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(WIDTH_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.step = (quo_reg < MIN_STEP) ? MIN_STEP : quo_reg;

endmodule

### rtl/horizontal_rescaler_rgb565_blend_top.sv
`timescale 1ns / 1ps

// Rescales RGB565 lines to 320 output pixels: wider sources merge pixel pairs by
// per-channel floor average, narrower ones insert averages, 320 passes through.
// An input beat is taken every cycle while the output keeps up; each beat makes
// zero, one or two output beats on the single-pixel master port, so on a narrow
// line the input rate is bounded by that port. A write to source_width starts a
// bit-serial step divider that holds both the config and input channels while it
// develops the 9 quotient bits and then loads the step; a write of 320 takes
// effect at once and holds nothing. Either write restarts the current line.
module horizontal_rescaler_rgb565_blend_top import hrs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  width_t       cfg_data,    // source_width
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,     // [15:0] source_pixel
    input  logic         s_tlast,     // line_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,     // [15:0] out_pixel
    output logic         m_tlast      // out_last
);

    width_t              width_reg, width_next;
    width_t              step_reg, step_next;
    width_t              rc_reg, rc_next;
    logic [OL_W-1:0]     ol_reg, ol_next;
    pixel_t              prev_reg, prev_next;
    logic                pp_reg, pp_next;
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   qcount_reg, qcount_next;
    pixel_t              q_pix_reg  [QDEPTH];
    logic                q_last_reg [QDEPTH];

    div_status_t         div_st;
    logic                s_fire, m_fire, cfg_fire;
    logic                wide, narrow, cfg_wide, active, first;
    width_t              cfg_diff, rc_dec, rc_step;
    logic                pp_step;
    logic [1:0]          cand_n, emit_n;
    pixel_t              cand0, cand1;
    logic                last0, last1;
    logic [QPTR_W-1:0]   wr_ptr_1;

    assign wide     = width_reg > OUT_W_W;
    assign narrow   = width_reg < OUT_W_W;
    assign cfg_wide = cfg_data > OUT_W_W;
    assign cfg_diff = cfg_wide ? cfg_data - OUT_W_W : OUT_W_W - cfg_data;

    assign cfg_ready = !div_st.busy && !div_st.done;
    assign s_tready  = !div_st.busy && !div_st.done && (qcount_reg <= QCNT_W'(QDEPTH - 2));
    assign m_tvalid  = qcount_reg != '0;
    assign m_tdata   = q_pix_reg[rd_ptr_reg];
    assign m_tlast   = q_last_reg[rd_ptr_reg];

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign cfg_fire = cfg_valid && cfg_ready;
    assign wr_ptr_1 = wr_ptr_reg + 1'b1;

    hrs_step_div u_step_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_fire && (cfg_diff != '0)),
        .divisor (cfg_diff),
        .status  (div_st)
    );

    always_comb begin
        active  = ol_reg != '0;
        first   = ol_reg == OL_W'(OUTPUT_WIDTH);
        rc_dec  = rc_reg - 1'b1;
        rc_step = rc_reg;
        pp_step = pp_reg;
        cand_n  = 2'd0;
        cand0   = s_tdata;
        cand1   = s_tdata;
        if (wide) begin
            if (rc_reg == '0) begin
                if (!pp_reg) begin
                    pp_step = 1'b1;
                end else begin
                    cand_n  = 2'd1;
                    cand0   = avg565(prev_reg, s_tdata);
                    pp_step = 1'b0;
                    rc_step = step_reg - 1'b1;
                end
            end else begin
                cand_n  = 2'd1;
                rc_step = rc_dec;
            end
        end else if (narrow) begin
            if (rc_dec == '0) begin
                cand_n  = 2'd2;
                cand0   = avg565(s_tdata, first ? s_tdata : prev_reg);
                rc_step = step_reg - 1'b1;
            end else begin
                cand_n  = 2'd1;
                rc_step = rc_dec;
            end
        end else begin
            cand_n = 2'd1;
        end

        if (!active) begin
            emit_n = 2'd0;
        end else if (ol_reg == OL_W'(1) && cand_n == 2'd2) begin
            emit_n = 2'd1;
        end else begin
            emit_n = cand_n;
        end
        last0 = ol_reg == OL_W'(1);
        last1 = ol_reg == OL_W'(2);
    end

    always_comb begin
        width_next  = width_reg;
        step_next   = step_reg;
        rc_next     = rc_reg;
        ol_next     = ol_reg;
        prev_next   = prev_reg;
        pp_next     = pp_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        qcount_next = qcount_reg + QCNT_W'(s_fire ? emit_n : 2'd0) - QCNT_W'(m_fire);

        if (s_fire) begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(emit_n);
            if (active) begin
                rc_next   = rc_step;
                pp_next   = pp_step;
                prev_next = s_tdata;
                ol_next   = ol_reg - OL_W'(emit_n);
            end
            if (s_tlast) begin
                rc_next   = wide ? step_reg : WIDTH_W'(1);
                ol_next   = OL_W'(OUTPUT_WIDTH);
                prev_next = '0;
                pp_next   = 1'b0;
            end
        end
        if (m_fire) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end

        if (cfg_fire) begin
            width_next = cfg_data;
            step_next  = '0;
            rc_next    = WIDTH_W'(1);
            ol_next    = OL_W'(OUTPUT_WIDTH);
            prev_next  = '0;
            pp_next    = 1'b0;
        end else if (div_st.done) begin
            step_next = div_st.step;
            rc_next   = wide ? div_st.step : WIDTH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= OUT_W_W;
            step_reg   <= '0;
            rc_reg     <= WIDTH_W'(1);
            ol_reg     <= OL_W'(OUTPUT_WIDTH);
            prev_reg   <= '0;
            pp_reg     <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            qcount_reg <= '0;
        end else begin
            width_reg  <= width_next;
            step_reg   <= step_next;
            rc_reg     <= rc_next;
            ol_reg     <= ol_next;
            prev_reg   <= prev_next;
            pp_reg     <= pp_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            qcount_reg <= qcount_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit_n != 2'd0) begin
            q_pix_reg[wr_ptr_reg]  <= cand0;
            q_last_reg[wr_ptr_reg] <= last0;
        end
        if (s_fire && emit_n == 2'd2) begin
            q_pix_reg[wr_ptr_1]  <= cand1;
            q_last_reg[wr_ptr_1] <= last1;
        end
    end

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcount_reg <= QCNT_W'(QDEPTH))
        else $error("output queue overflow");

    a_outputs_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ol_reg <= OL_W'(OUTPUT_WIDTH))
        else $error("outputs_left above line width");

    a_hold_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.busy |-> (!s_tready && !cfg_ready))
        else $error("channel open while step divider runs");

    a_narrow_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (narrow && !div_st.busy && !div_st.done) |-> (rc_reg != '0))
        else $error("narrow run counter reached zero");

    a_step_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |=> (step_reg >= MIN_STEP))
        else $error("loaded step below minimum");
`endif

endmodule

### tb/rescaled_line_checker.sv
`timescale 1ns / 1ps

module rescaled_line_checker import hrs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  width_t      cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          backlog,
    output int          beats_checked
);

    typedef struct packed {
        pixel_t pix;
        logic   last;
    } out_beat_t;

    out_beat_t       expected_pixels[$];
    out_beat_t       want;
    width_t          src_width;
    width_t          run_step;
    width_t          run_count;
    logic [OL_W-1:0] outputs_left;
    pixel_t          prev_pixel;
    logic            pair_held;
    logic            line_full;

    function automatic width_t derive_run_step(input width_t w);
        int diff;
        int q;
        diff = (w > OUT_W_W) ? int'(w) - OUTPUT_WIDTH : OUTPUT_WIDTH - int'(w);
        if (diff == 0)
            return '0;
        q = OUTPUT_WIDTH / diff;
        return (q < 2) ? MIN_STEP : width_t'(q);
    endfunction

    function automatic pixel_t blend565(input pixel_t a, input pixel_t b);
        int r;
        int g;
        int bl;
        r  = (int'(a[15:11]) + int'(b[15:11])) / 2;
        g  = (int'(a[10:5]) + int'(b[10:5])) / 2;
        bl = (int'(a[4:0]) + int'(b[4:0])) / 2;
        return pixel_t'((r << 11) | (g << 5) | bl);
    endfunction

    task automatic restart_line();
        run_count    = (src_width > OUT_W_W) ? run_step : width_t'(1);
        outputs_left = OL_W'(OUTPUT_WIDTH);
        prev_pixel   = '0;
        pair_held    = 1'b0;
        line_full    = 1'b0;
    endtask

    task automatic emit_pixel(input pixel_t p);
        if (line_full || outputs_left == 0)
            return;
        outputs_left--;
        expected_pixels.push_back('{p, outputs_left == 0});
        if (outputs_left == 0)
            line_full = 1'b1;
    endtask

    task automatic predict_outputs(input pixel_t p, input logic end_of_line);
        logic first;
        if (!line_full) begin
            if (src_width > OUT_W_W) begin
                if (run_count == 0) begin
                    if (!pair_held) begin
                        pair_held = 1'b1;
                    end else begin
                        emit_pixel(blend565(prev_pixel, p));
                        pair_held = 1'b0;
                        run_count = run_step - 1'b1;
                    end
                end else begin
                    emit_pixel(p);
                    run_count--;
                end
            end else if (src_width < OUT_W_W) begin
                first = (outputs_left == OL_W'(OUTPUT_WIDTH));
                run_count--;
                if (run_count == 0) begin
                    emit_pixel(blend565(p, first ? p : prev_pixel));
                    run_count = run_step - 1'b1;
                end
                emit_pixel(p);
            end else begin
                emit_pixel(p);
            end
            prev_pixel = p;
        end
        if (end_of_line)
            restart_line();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            src_width = OUT_W_W;
            run_step  = derive_run_step(src_width);
            restart_line();
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                src_width = cfg_data;
                run_step  = derive_run_step(src_width);
                restart_line();
            end
            if (s_tvalid && s_tready)
                predict_outputs(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected output beat, expected none, actual pixel %h last %b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = expected_pixels.pop_front();
                    beats_checked++;
                    if (m_tdata !== want.pix || m_tlast !== want.last) begin
                        mismatches++;
                        $display("%0t: output beat mismatch, expected pixel %h last %b,",
                                 $time, want.pix, want.last);
                        $display("%0t:     actual pixel %h last %b",
                                 $time, m_tdata, m_tlast);
                    end
                end
            end
        end
        backlog = expected_pixels.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import hrs_pkg::*;

    localparam int ITEM_TARGET    = 1850;
    localparam int MAX_WAIT       = 11;
    localparam int SETTLE_CYCLES  = 20;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    width_t      cfg_data  = OUT_W_W;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    int   mismatches;
    int   backlog;
    int   beats_checked;
    int   items_sent   = 0;
    int   lines_sent   = 0;
    int   widths_set   = 0;
    int   idle_cycles  = 0;
    int   stall_left   = 0;
    logic m_moved      = 1'b0;
    logic tx_quiet     = 1'b1;
    logic rx_quiet     = 1'b0;

    always #5 aclk = ~aclk;

    horizontal_rescaler_rgb565_blend_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    rescaled_line_checker line_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .backlog       (backlog),
        .beats_checked (beats_checked)
    );

    always @(posedge aclk) begin
        m_moved <= m_tvalid && m_tready;
    end

    // hold off the output side for a fresh random count after every beat, or not at all while rx_quiet
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_moved)
                stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready) || (s_tvalid && s_tready)
                || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("horizontal_rescaler_rgb565_blend_top test failed");
                $finish;
            end
        end
    end

    task automatic send_pixel(input pixel_t pix, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge aclk);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_pixels(input pixel_t px[$], input logic close);
        foreach (px[i])
            send_pixel(px[i], close && i == px.size() - 1);
        lines_sent++;
    endtask

    task automatic send_line(input int len, input logic close);
        for (int i = 0; i < len; i++)
            send_pixel(pixel_t'($urandom_range(0, 65535)), close && i == len - 1);
        lines_sent++;
    endtask

    task automatic drain(input int settle);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (backlog != 0)
            @(negedge aclk);
        repeat (settle) @(negedge aclk);
    endtask

    task automatic write_width(input width_t w);
        drain(SETTLE_CYCLES);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        widths_set++;
    endtask

    initial begin
        pixel_t primaries[$];
        pixel_t blends[$];
        pixel_t pairs[$];
        width_t sweep[$];
        width_t w;
        int     phase;
        int     base;
        int     len;
        int     pick;

        primaries = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hAAAA, 16'h5555};
        blends    = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'hF81F, 16'h07E0, 16'h0821};
        pairs     = '{16'hFFFF, 16'h0001, 16'h0820, 16'hFFFF, 16'h0000, 16'hF7DE, 16'h0841};
        sweep     = '{9'd320, 9'd160, 9'd480, 9'd0, 9'd511, 9'd319, 9'd321};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_pixels(primaries, 1'b1);
        write_width(9'd160);
        send_pixels(blends, 1'b1);
        write_width(9'd511);
        // leave this line open so the next width write restarts it
        send_pixels(pairs, 1'b0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < sweep.size())
                w = sweep[phase];
            else if ($urandom_range(0, 3) == 0)
                w = width_t'($urandom_range(0, 511));
            else
                w = width_t'($urandom_range(160, 480));
            write_width(w);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            base = (w == 0) ? 1 : int'(w);
            if (phase < sweep.size()) begin
                if (w == 0 || w == 9'd511)
                    send_line($urandom_range(1, 40), 1'b1);
                else
                    send_line(base, 1'b1);
                send_line($urandom_range(1, 30), $urandom_range(0, 5) != 0);
            end else begin
                pick = $urandom_range(0, 3);
                if (pick < 2)
                    len = base;
                else if (pick == 2)
                    len = $urandom_range(1, base);
                else
                    len = base + $urandom_range(1, 20);
                if (len > ITEM_TARGET - items_sent)
                    len = ITEM_TARGET - items_sent;
                send_line(len, $urandom_range(0, 5) != 0);
            end
            phase++;
        end

        drain(TAIL_CYCLES);
        $display("Sent %0d source pixels in %0d lines across %0d source width settings",
                 items_sent, lines_sent, widths_set);
        $display("Compared %0d output pixels, %0d mismatches", beats_checked, mismatches);
        if (mismatches == 0)
            $display("horizontal_rescaler_rgb565_blend_top test passed");
        else
            $display("horizontal_rescaler_rgb565_blend_top test failed");
        $finish;
    end

endmodule

### filelist.f
rtl/hrs_pkg.sv
rtl/hrs_step_div.sv
rtl/horizontal_rescaler_rgb565_blend_top.sv
tb/rescaled_line_checker.sv
tb/tb.sv
